// File: rtl/qts_pkg.sv
`default_nettype none
package qts_pkg;

	localparam int KEYWORD_MAX_DEF = 6;
	localparam int MAX_OUT = 6;
	localparam int CNT_W = 3;
	localparam int NUM_KW = 10;

	localparam logic [8:0] SYM_END = 9'h100;

	localparam logic [4:0] TK_TEXT   = 5'd0;
	localparam logic [4:0] TK_END    = 5'd1;
	localparam logic [4:0] TK_BOOL   = 5'd10;
	localparam logic [4:0] TK_IDENT  = 5'd11;
	localparam logic [4:0] TK_INT    = 5'd12;
	localparam logic [4:0] TK_REAL   = 5'd13;
	localparam logic [4:0] TK_STRING = 5'd14;
	localparam logic [4:0] TK_EQ     = 5'd15;
	localparam logic [4:0] TK_NE     = 5'd16;
	localparam logic [4:0] TK_LE     = 5'd17;
	localparam logic [4:0] TK_LT     = 5'd18;
	localparam logic [4:0] TK_GE     = 5'd19;
	localparam logic [4:0] TK_GT     = 5'd20;
	localparam logic [4:0] TK_STAR   = 5'd21;
	localparam logic [4:0] TK_LPAREN = 5'd22;
	localparam logic [4:0] TK_RPAREN = 5'd23;
	localparam logic [4:0] TK_COMMA  = 5'd24;
	localparam logic [4:0] TK_ERROR  = 5'd25;

	localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

	// keywords right-justified: first char is the highest used byte
	localparam logic [NUM_KW-1:0][47:0] KW_WORD = '{
		48'("false"), 48'("true"), 48'("like"), 48'("null"), 48'("or"),
		48'("and"), 48'("not"), 48'("where"), 48'("from"), 48'("select")};
	localparam logic [NUM_KW-1:0][2:0] KW_LEN = '{
		3'd5, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd3, 3'd5, 3'd4, 3'd6};
	localparam logic [NUM_KW-1:0][4:0] KW_KIND = '{
		5'd10, 5'd10, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2};
	localparam logic [NUM_KW-1:0] KW_BOOL = 10'b01_0000_0000;

	typedef enum logic [3:0] {
		MODE_IDLE, MODE_IDENT, MODE_SIGN, MODE_SIGN_DOT, MODE_INT, MODE_FRAC,
		MODE_EXP1, MODE_EXP2, MODE_EXPD, MODE_STR, MODE_ESC, MODE_LT, MODE_GT,
		MODE_BANG
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		logic [4:0]         token_kind;
		logic [7:0]         text_char;
		logic signed [63:0] int_value;
		logic               bool_value;
		logic               last;
	} out_word_t;

	typedef struct packed {
		out_word_t [MAX_OUT-1:0] w;
		logic [CNT_W-1:0]        n;
	} emit_list_t;

endpackage
`default_nettype wire

// File: rtl/query_token_scanner.sv
// channel | dir | valid     | stall     | payload
// chr     | in  | chr_valid | chr_stall | chr (in_word_t: char_code, end_of_input)
// tok     | out | tok_valid | tok_stall | tok (out_word_t: kind, text, int, bool, last)
//
// One character is scanned per cycle; its 0 to 6 words land in a result queue
// and drain one per cycle while tok_stall is low.
// A new character is taken when the queue is empty or its last word leaves.
// Reset puts the scanner between tokens; the queue comes up empty.
// tok_stall holds the queue head; chr_stall is high while any word waits that
// does not leave in this cycle.
`default_nettype none
module query_token_scanner import qts_pkg::*; #(
	parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      chr_valid,
	output logic           chr_stall,
	input  wire in_word_t  chr,
	output logic           tok_valid,
	input  wire logic      tok_stall,
	output out_word_t      tok
);

	emit_list_t       list;
	out_word_t [MAX_OUT-1:0] q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             take, accept;
	logic [8:0]       sym;

	assign sym       = chr.end_of_input ? SYM_END : {1'b0, chr.char_code};
	assign tok_valid = (cnt_q != '0);
	assign tok       = q_q[0];
	assign take      = tok_valid && !tok_stall;
	assign chr_stall = !((cnt_q == '0) || (cnt_q == CNT_W'(1) && take));
	assign accept    = chr_valid && !chr_stall;

	qts_lexer #(.KEYWORD_MAX(KEYWORD_MAX)) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (accept),
		.sym     (sym),
		.list    (list)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= list.n;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q <= list.w;
		end else if (take) begin
			for (int i = 0; i < MAX_OUT - 1; i++)
				q_q[i] <= q_q[i+1];
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && list.n != '0 |=> tok_valid && tok == $past(list.w[0]))
		else $error("queue head not loaded");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |-> chr_stall)
		else $error("char taken while queue head stalled");

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_OUT))
		else $error("queue count overflow");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!accept && take |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("queue count not decremented");

endmodule
`default_nettype wire

// File: rtl/qts_lexer.sv
`default_nettype none
module qts_lexer import qts_pkg::*; #(
	parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire logic [8:0] sym,
	output emit_list_t      list
);

	localparam int LEN_W = $clog2(KEYWORD_MAX + 2);

	typedef struct packed {
		scan_mode_t                   mode;
		logic [KEYWORD_MAX-1:0][7:0]  kw;
		logic [LEN_W-1:0]             len;
		logic [63:0]                  acc;
		logic                         neg;
		logic                         quote;
		logic [1:0][7:0]              held;
	} lex_state_t;

	typedef struct packed {
		lex_state_t st;
		emit_list_t e;
		logic       again;
	} scan_t;

	lex_state_t st_q, st_d;

	function automatic emit_list_t put(emit_list_t e, out_word_t w);
		if (e.n < CNT_W'(MAX_OUT)) begin
			e.w[e.n] = w;
			e.n      = e.n + CNT_W'(1);
		end
		return e;
	endfunction

	function automatic out_word_t txt(logic [7:0] c);
		out_word_t w;
		w = '0;
		w.token_kind = TK_TEXT;
		w.text_char  = c;
		return w;
	endfunction

	function automatic out_word_t tok(logic [4:0] k);
		out_word_t w;
		w = '0;
		w.token_kind = k;
		w.last       = 1'b1;
		return w;
	endfunction

	// saturate magnitude at 2^63: acc*10+d > 2^63 means overflow
	function automatic logic [63:0] accum(logic [63:0] acc, logic [3:0] d);
		logic [67:0] t;
		t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {64'b0, d};
		return (t > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : t[63:0];
	endfunction

	function automatic scan_t push_ident(scan_t x, logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
		for (int i = 0; i < KEYWORD_MAX; i++)
			if (x.st.len == LEN_W'(i))
				x.st.kw[i] = lc;
		if (x.st.len < LEN_W'(KEYWORD_MAX + 1))
			x.st.len = x.st.len + LEN_W'(1);
		x.e = put(x.e, txt(c));
		return x;
	endfunction

	function automatic emit_list_t finish_ident(emit_list_t e, lex_state_t s);
		logic found, eq;
		out_word_t w;
		found = 1'b0;
		w = tok(TK_IDENT);
		for (int i = 0; i < NUM_KW; i++) begin
			eq = (s.len == LEN_W'(KW_LEN[i]));
			for (int k = 0; k < 6; k++)
				if (k < int'(KW_LEN[i]))
					if (s.kw[k] != KW_WORD[i][8*(int'(KW_LEN[i])-1-k) +: 8])
						eq = 1'b0;
			if (eq && !found) begin
				found = 1'b1;
				w = tok(KW_KIND[i]);
				w.bool_value = KW_BOOL[i];
			end
		end
		return put(e, w);
	endfunction

	function automatic emit_list_t finish_int(emit_list_t e, lex_state_t s);
		out_word_t w;
		w = tok(TK_INT);
		if (s.neg)
			w.int_value = 64'd0 - s.acc;
		else
			w.int_value = (s.acc >= MAG_LIMIT) ? MAG_LIMIT - 64'd1 : s.acc;
		return put(e, w);
	endfunction

	// one symbol in the current mode; again asks for a rescan from idle
	function automatic scan_t scan1(scan_t x, logic [8:0] s);
		logic [7:0] c, sign_ch;
		logic digit, alpha, space, sgn;
		c       = s[7:0];
		sign_ch = x.st.neg ? 8'h2D : 8'h2B;
		digit   = s inside {[9'h030:9'h039]};
		alpha   = s inside {[9'h041:9'h05A], [9'h061:9'h07A]};
		space   = s inside {9'h020, [9'h009:9'h00D]};
		sgn     = s inside {9'h02B, 9'h02D};
		x.again = 1'b0;
		case (x.st.mode)
			MODE_IDLE: begin
				if (s == SYM_END) x.e = put(x.e, tok(TK_END));
				else if (space) x.again = 1'b0;
				else if (alpha || s == 9'h05F) begin
					x.st.mode = MODE_IDENT;
					x.st.len  = '0;
					x = push_ident(x, c);
				end else if (digit) begin
					x.st.neg  = 1'b0;
					x.st.acc  = accum(64'd0, c[3:0]);
					x.st.mode = MODE_INT;
					x.e = put(x.e, txt(c));
				end else if (sgn) begin
					x.st.neg  = (s == 9'h02D);
					x.st.acc  = '0;
					x.st.mode = MODE_SIGN;
				end else if (s == 9'h022) begin
					x.st.quote = 1'b0;
					x.st.mode  = MODE_STR;
				end else if (s == 9'h027) begin
					x.st.quote = 1'b1;
					x.st.mode  = MODE_STR;
				end else if (s == 9'h03D) x.e = put(x.e, tok(TK_EQ));
				else if (s == 9'h03C) x.st.mode = MODE_LT;
				else if (s == 9'h03E) x.st.mode = MODE_GT;
				else if (s == 9'h021) x.st.mode = MODE_BANG;
				else if (s == 9'h02A) x.e = put(x.e, tok(TK_STAR));
				else if (s == 9'h028) x.e = put(x.e, tok(TK_LPAREN));
				else if (s == 9'h029) x.e = put(x.e, tok(TK_RPAREN));
				else if (s == 9'h02C) x.e = put(x.e, tok(TK_COMMA));
				else x.e = put(x.e, tok(TK_ERROR));
			end
			MODE_IDENT: begin
				if (alpha || digit || s == 9'h05F) x = push_ident(x, c);
				else begin
					x.e = finish_ident(x.e, x.st);
					x.st.mode = MODE_IDLE;
					x.again = 1'b1;
				end
			end
			MODE_SIGN: begin
				if (digit) begin
					x.e = put(x.e, txt(sign_ch));
					x.e = put(x.e, txt(c));
					x.st.acc  = accum(x.st.acc, c[3:0]);
					x.st.mode = MODE_INT;
				end else if (s == 9'h02E) x.st.mode = MODE_SIGN_DOT;
				else begin
					x.e = put(x.e, tok(TK_ERROR));
					x.st.mode = MODE_IDLE;
					x.again = 1'b1;
				end
			end
			MODE_SIGN_DOT: begin
				if (digit) begin
					x.e = put(x.e, txt(sign_ch));
					x.e = put(x.e, txt(8'h2E));
					x.e = put(x.e, txt(c));
					x.st.mode = MODE_FRAC;
				end else begin
					x.e = put(x.e, tok(TK_ERROR));
					x.st.mode = MODE_IDLE;
					x.again = 1'b1;
				end
			end
			MODE_INT: begin
				if (digit) begin
					x.e = put(x.e, txt(c));
					x.st.acc = accum(x.st.acc, c[3:0]);
				end else if (s == 9'h02E) begin
					x.e = put(x.e, txt(c));
					x.st.mode = MODE_FRAC;
				end else begin
					x.e = finish_int(x.e, x.st);
					x.st.mode = MODE_IDLE;
					x.again = 1'b1;
				end
			end
			MODE_FRAC: begin
				if (digit) x.e = put(x.e, txt(c));
				else if (s == 9'h065 || s == 9'h045) begin
					x.st.held[0] = c;
					x.st.mode = MODE_EXP1;
				end else begin
					x.e = put(x.e, tok(TK_REAL));
					x.st.mode = MODE_IDLE;
					x.again = 1'b1;
				end
			end
			MODE_EXP1: begin
				if (digit) begin
					x.e = put(x.e, txt(x.st.held[0]));
					x.e = put(x.e, txt(c));
					x.st.mode = MODE_EXPD;
				end else begin
					x.st.held[1] = c;
					x.st.mode = MODE_EXP2;
				end
			end
			MODE_EXP2: begin
				x.e = put(x.e, txt(x.st.held[0]));
				x.e = put(x.e, txt(x.st.held[1]));
				x.e = put(x.e, txt(c));
				x.st.mode = MODE_EXPD;
			end
			MODE_EXPD: begin
				if (digit) x.e = put(x.e, txt(c));
				else begin
					x.e = put(x.e, tok(TK_REAL));
					x.st.mode = MODE_IDLE;
					x.again = 1'b1;
				end
			end
			MODE_STR: begin
				if (s == SYM_END) begin
					x.e = put(x.e, tok(TK_ERROR));
					x.st.mode = MODE_IDLE;
					x.again = 1'b1;
				end else if (s == (x.st.quote ? 9'h027 : 9'h022)) begin
					x.e = put(x.e, tok(TK_STRING));
					x.st.mode = MODE_IDLE;
				end else if (s == 9'h05C) x.st.mode = MODE_ESC;
				else x.e = put(x.e, txt(c));
			end
			MODE_ESC: begin
				if (s == SYM_END) begin
					x.e = put(x.e, tok(TK_ERROR));
					x.st.mode = MODE_IDLE;
					x.again = 1'b1;
				end else begin
					if (s == 9'h06E) x.e = put(x.e, txt(8'd10));
					else if (s == 9'h072 || s == 9'h066) x.e = put(x.e, txt(8'd13));
					else x.e = put(x.e, txt(c));
					x.st.mode = MODE_STR;
				end
			end
			MODE_LT: begin
				x.st.mode = MODE_IDLE;
				if (s == 9'h03E) x.e = put(x.e, tok(TK_NE));
				else if (s == 9'h03D) x.e = put(x.e, tok(TK_LE));
				else begin
					x.e = put(x.e, tok(TK_LT));
					x.again = 1'b1;
				end
			end
			MODE_GT: begin
				x.st.mode = MODE_IDLE;
				if (s == 9'h03D) x.e = put(x.e, tok(TK_GE));
				else begin
					x.e = put(x.e, tok(TK_GT));
					x.again = 1'b1;
				end
			end
			MODE_BANG: begin
				x.st.mode = MODE_IDLE;
				if (s == 9'h03D) x.e = put(x.e, tok(TK_NE));
				else begin
					x.e = put(x.e, tok(TK_ERROR));
					x.again = 1'b1;
				end
			end
			default: begin
				x.st.mode = MODE_IDLE;
				x.again = 1'b1;
			end
		endcase
		return x;
	endfunction

	function automatic scan_t feed(scan_t x, logic [8:0] s);
		x = scan1(x, s);
		if (x.again)
			x = scan1(x, s);
		x.again = 1'b0;
		return x;
	endfunction

	function automatic scan_t step(lex_state_t st, logic [8:0] s);
		scan_t x;
		logic digit, sgn, bad1, bad2;
		logic [7:0] h0, h1;
		x       = '0;
		x.st    = st;
		digit   = s inside {[9'h030:9'h039]};
		sgn     = s inside {9'h02B, 9'h02D};
		bad1    = (st.mode == MODE_EXP1) && !digit && !sgn;
		bad2    = (st.mode == MODE_EXP2) && !digit;
		h0      = st.held[0];
		h1      = st.held[1];
		if (bad1 || bad2) begin
			// incomplete exponent: close the real, rescan the held chars, then this one
			x.e = put(x.e, tok(TK_REAL));
			x.st.mode = MODE_IDLE;
			x = feed(x, {1'b0, h0});
			if (bad2)
				x = feed(x, {1'b0, h1});
			x = feed(x, s);
		end else begin
			x = feed(x, s);
		end
		return x;
	endfunction

	scan_t res;

	always_comb begin
		res  = step(st_q, sym);
		st_d = res.st;
		list = res.e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_IDLE, default: '0};
		end else if (step_en) begin
			st_q <= st_d;
		end
	end

endmodule
`default_nettype wire

// File: verif/tb_query_token_scanner.sv
`default_nettype none
module tb_query_token_scanner;
	import qts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		SC_IDLE, SC_IDENT, SC_SIGN, SC_SIGN_DOT, SC_INT, SC_FRAC, SC_EXP1, SC_EXP2,
		SC_EXPD, SC_STR, SC_ESC, SC_LT, SC_GT, SC_BANG
	} lex_mode_t;

	localparam int STALL_PCT = 37;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [4:0] TK_SELECT = 5'd2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic chr_valid = 1'b0;
	logic chr_stall;
	in_word_t chr = '0;
	logic tok_valid;
	logic tok_stall = 1'b1;
	out_word_t tok;

	query_token_scanner uut (
		.clk(clk), .arst_n(arst_n),
		.chr_valid(chr_valid), .chr_stall(chr_stall), .chr(chr),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok(tok)
	);

	always #5 clk = ~clk;

	// predictor state
	lex_mode_t lx_mode;
	logic [7:0] lx_kw [6];
	int unsigned lx_len;
	logic [63:0] lx_mag;
	bit lx_neg;
	bit lx_single;
	logic [7:0] lx_held [2];

	out_word_t token_queue [$];
	int errors = 0;
	int words_sent = 0;
	int tokens_seen = 0;
	bit quiet_sink = 0;      // sink never stalls
	bit quiet_src = 0;       // source never idles
	bit hold_sink = 0;       // long hold-off in progress
	int idle_cycles = 0;

	function automatic void push_tok(logic [4:0] k, logic [7:0] c, logic [63:0] v, bit b,
		bit l);
		out_word_t w;
		w.token_kind = k;
		w.text_char = c;
		w.int_value = v;
		w.bool_value = b;
		w.last = l;
		token_queue.push_back(w);
	endfunction

	function automatic bit is_dig(int s);
		return s >= "0" && s <= "9";
	endfunction

	function automatic bit is_alp(int s);
		return (s >= "a" && s <= "z") || (s >= "A" && s <= "Z");
	endfunction

	function automatic void add_digit(int d);
		if (lx_mag > (MAG_LIMIT - 64'(d)) / 10)
			lx_mag = MAG_LIMIT;
		else
			lx_mag = lx_mag * 10 + 64'(d);
	endfunction

	function automatic void ident_char(int c);
		if (lx_len < 6)
			lx_kw[lx_len] = (c >= "A" && c <= "Z") ? 8'(c + 32) : 8'(c);
		if (lx_len < 7)
			lx_len++;
		push_tok(TK_TEXT, 8'(c), 0, 0, 0);
	endfunction

	function automatic void close_ident();
		string words [10] = '{"select", "from", "where", "not", "and", "or", "null",
			"like", "true", "false"};
		bit hit;
		for (int i = 0; i < 10; i++) begin
			hit = (lx_len == words[i].len());
			for (int k = 0; hit && k < words[i].len(); k++)
				if (lx_kw[k] != words[i][k])
					hit = 0;
			if (hit) begin
				if (i >= 8)
					push_tok(TK_BOOL, 0, 0, i == 8, 1);
				else
					push_tok(5'(TK_SELECT + i), 0, 0, 0, 1);
				return;
			end
		end
		push_tok(TK_IDENT, 0, 0, 0, 1);
	endfunction

	// s == 256 means end of text
	function automatic void scan_symbol(int s);
		logic [7:0] sgn;
		logic [7:0] h0, h1;
		sgn = lx_neg ? "-" : "+";
		case (lx_mode)
		SC_IDLE: begin
			if (s == 256) push_tok(TK_END, 0, 0, 0, 1);
			else if (s == " " || (s >= 9 && s <= 13)) ;
			else if (is_alp(s) || s == "_") begin
				lx_mode = SC_IDENT;
				lx_len = 0;
				ident_char(s);
			end else if (is_dig(s)) begin
				lx_neg = 0;
				lx_mag = 0;
				lx_mode = SC_INT;
				push_tok(TK_TEXT, 8'(s), 0, 0, 0);
				add_digit(s - "0");
			end else if (s == "+" || s == "-") begin
				lx_neg = (s == "-");
				lx_mag = 0;
				lx_mode = SC_SIGN;
			end else if (s == "\"") begin
				lx_single = 0;
				lx_mode = SC_STR;
			end else if (s == "'") begin
				lx_single = 1;
				lx_mode = SC_STR;
			end else if (s == "=") push_tok(TK_EQ, 0, 0, 0, 1);
			else if (s == "<") lx_mode = SC_LT;
			else if (s == ">") lx_mode = SC_GT;
			else if (s == "!") lx_mode = SC_BANG;
			else if (s == "*") push_tok(TK_STAR, 0, 0, 0, 1);
			else if (s == "(") push_tok(TK_LPAREN, 0, 0, 0, 1);
			else if (s == ")") push_tok(TK_RPAREN, 0, 0, 0, 1);
			else if (s == ",") push_tok(TK_COMMA, 0, 0, 0, 1);
			else push_tok(TK_ERROR, 0, 0, 0, 1);
		end
		SC_IDENT: begin
			if (s != 256 && (is_alp(s) || is_dig(s) || s == "_")) ident_char(s);
			else begin
				close_ident();
				lx_mode = SC_IDLE;
				scan_symbol(s);
			end
		end
		SC_SIGN: begin
			if (s != 256 && is_dig(s)) begin
				push_tok(TK_TEXT, sgn, 0, 0, 0);
				push_tok(TK_TEXT, 8'(s), 0, 0, 0);
				add_digit(s - "0");
				lx_mode = SC_INT;
			end else if (s == ".") lx_mode = SC_SIGN_DOT;
			else begin
				push_tok(TK_ERROR, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(s);
			end
		end
		SC_SIGN_DOT: begin
			if (s != 256 && is_dig(s)) begin
				push_tok(TK_TEXT, sgn, 0, 0, 0);
				push_tok(TK_TEXT, ".", 0, 0, 0);
				push_tok(TK_TEXT, 8'(s), 0, 0, 0);
				lx_mode = SC_FRAC;
			end else begin
				push_tok(TK_ERROR, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(s);
			end
		end
		SC_INT: begin
			if (s != 256 && is_dig(s)) begin
				push_tok(TK_TEXT, 8'(s), 0, 0, 0);
				add_digit(s - "0");
			end else if (s == ".") begin
				push_tok(TK_TEXT, ".", 0, 0, 0);
				lx_mode = SC_FRAC;
			end else begin
				if (lx_neg) push_tok(TK_INT, 0, 64'd0 - lx_mag, 0, 1);
				else push_tok(TK_INT, 0, lx_mag >= MAG_LIMIT ? MAG_LIMIT - 1 : lx_mag, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(s);
			end
		end
		SC_FRAC: begin
			if (s != 256 && is_dig(s)) push_tok(TK_TEXT, 8'(s), 0, 0, 0);
			else if (s == "e" || s == "E") begin
				lx_held[0] = 8'(s);
				lx_mode = SC_EXP1;
			end else begin
				push_tok(TK_REAL, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(s);
			end
		end
		SC_EXP1: begin
			if (s != 256 && is_dig(s)) begin
				push_tok(TK_TEXT, lx_held[0], 0, 0, 0);
				push_tok(TK_TEXT, 8'(s), 0, 0, 0);
				lx_mode = SC_EXPD;
			end else if (s == "+" || s == "-") begin
				lx_held[1] = 8'(s);
				lx_mode = SC_EXP2;
			end else begin
				push_tok(TK_REAL, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(lx_held[0]);
				scan_symbol(s);
			end
		end
		SC_EXP2: begin
			if (s != 256 && is_dig(s)) begin
				push_tok(TK_TEXT, lx_held[0], 0, 0, 0);
				push_tok(TK_TEXT, lx_held[1], 0, 0, 0);
				push_tok(TK_TEXT, 8'(s), 0, 0, 0);
				lx_mode = SC_EXPD;
			end else begin
				h0 = lx_held[0];
				h1 = lx_held[1];
				push_tok(TK_REAL, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(h0);
				scan_symbol(h1);
				scan_symbol(s);
			end
		end
		SC_EXPD: begin
			if (s != 256 && is_dig(s)) push_tok(TK_TEXT, 8'(s), 0, 0, 0);
			else begin
				push_tok(TK_REAL, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(s);
			end
		end
		SC_STR: begin
			if (s == 256) begin
				push_tok(TK_ERROR, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(s);
			end else if (s == (lx_single ? "'" : "\"")) begin
				push_tok(TK_STRING, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
			end else if (s == "\\") lx_mode = SC_ESC;
			else push_tok(TK_TEXT, 8'(s), 0, 0, 0);
		end
		SC_ESC: begin
			if (s == 256) begin
				push_tok(TK_ERROR, 0, 0, 0, 1);
				lx_mode = SC_IDLE;
				scan_symbol(s);
			end else begin
				if (s == "n") push_tok(TK_TEXT, 8'd10, 0, 0, 0);
				else if (s == "r" || s == "f") push_tok(TK_TEXT, 8'd13, 0, 0, 0);
				else push_tok(TK_TEXT, 8'(s), 0, 0, 0);
				lx_mode = SC_STR;
			end
		end
		SC_LT: begin
			lx_mode = SC_IDLE;
			if (s == ">") push_tok(TK_NE, 0, 0, 0, 1);
			else if (s == "=") push_tok(TK_LE, 0, 0, 0, 1);
			else begin
				push_tok(TK_LT, 0, 0, 0, 1);
				scan_symbol(s);
			end
		end
		SC_GT: begin
			lx_mode = SC_IDLE;
			if (s == "=") push_tok(TK_GE, 0, 0, 0, 1);
			else begin
				push_tok(TK_GT, 0, 0, 0, 1);
				scan_symbol(s);
			end
		end
		default: begin
			lx_mode = SC_IDLE;
			if (s == "=") push_tok(TK_NE, 0, 0, 0, 1);
			else begin
				push_tok(TK_ERROR, 0, 0, 0, 1);
				scan_symbol(s);
			end
		end
		endcase
	endfunction

	// valid stays up after a word is taken; the next call or the caller drops it
	task automatic send_word(logic [7:0] c, bit eoi);
		while (!quiet_src && $urandom_range(99) < STALL_PCT) begin
			chr_valid <= 1'b0;
			@(posedge clk);
		end
		chr_valid <= 1'b1;
		chr.char_code <= c;
		chr.end_of_input <= eoi;
		@(posedge clk);
		while (chr_stall)
			@(posedge clk);
		scan_symbol(eoi ? 256 : int'(c));
		words_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 0);
	endtask

	// sink side: random stall, quiet stretch, or forced hold-off
	always @(posedge clk) begin
		if (!arst_n)
			tok_stall <= 1'b1;
		else
			tok_stall <= hold_sink || (!quiet_sink && $urandom_range(99) < STALL_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall) begin
			tokens_seen++;
			if (token_queue.size() == 0) begin
				$display("%0t: unexpected token word: actual %p", $realtime, tok);
				errors++;
			end else begin
				out_word_t want;
				want = token_queue.pop_front();
				if (tok.token_kind != want.token_kind || tok.text_char != want.text_char ||
						tok.int_value != want.int_value || tok.bool_value != want.bool_value ||
						tok.last != want.last) begin
					$display("%0t: token mismatch: expected %p actual %p", $realtime, want, tok);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((chr_valid && !chr_stall) || (tok_valid && !tok_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_keywords();
		send_text("SELECT a_1,from WHERE not And oR NULL like TRUE false selects x*(y) ");
		send_word(0, 1);
	endtask

	task automatic test_numbers();
		send_text("0 -17 +42 9223372036854775807 9223372036854775808 ");
		send_text("-9223372036854775808 -99999999999999999999 ");
		send_text("3.14 -.5 +.x - 1e5 2.5e 7.1e+ 6.0E-3 1.2e9 +");
		send_word(0, 1);
	endtask

	task automatic test_strings_ops();
		send_text("'it\\'s' \"a\\nb\\rc\\fd\\q\" = <> != <= < >= > <x >y !x ! # ");
		send_word(8'h00, 0);
		send_word(8'hff, 0);
		send_word(8'h80, 0);
		send_text("\"open");
		send_word(0, 1);
		send_text("'esc\\");
		send_word(0, 1);
		send_word(0, 1);
	endtask

	function automatic string rand_piece();
		string alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		string kws [10] = '{"SELECT", "from", "Where", "NOT", "and", "Or", "null",
			"LIKE", "true", "False"};
		string ops [12] = '{"=", "<>", "!=", "<=", "<", ">=", ">", "*", "(", ")", ",", "!"};
		string r;
		int n;
		r = "";
		case ($urandom_range(7))
		0: r = kws[$urandom_range(9)];
		1: begin
			n = $urandom_range(1, 8);
			r = {r, string'(alpha[$urandom_range(52)])};
			for (int i = 1; i < n; i++) r = {r, string'(alpha[$urandom_range(62)])};
		end
		2: begin
			if ($urandom_range(1)) r = ($urandom_range(1)) ? "-" : "+";
			n = $urandom_range(1, 22);
			for (int i = 0; i < n; i++) r = {r, string'(8'("0" + $urandom_range(9)))};
		end
		3: begin
			r = $sformatf("%0d.%0d", $urandom_range(99), $urandom_range(999));
			if ($urandom_range(1)) r = {r, ($urandom_range(1) ? "e" : "E"),
				($urandom_range(2) == 0 ? "" : ($urandom_range(1) ? "-" : "+")),
				($urandom_range(3) == 0 ? "" : $sformatf("%0d", $urandom_range(99)))};
		end
		4: begin
			r = $urandom_range(1) ? "'" : "\"";
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				case ($urandom_range(3))
				0: r = {r, "\\", string'(8'($urandom_range(32, 126)))};
				default: r = {r, string'(alpha[$urandom_range(62)])};
				endcase
			r = {r, r.substr(0, 0)};
		end
		5: r = ops[$urandom_range(11)];
		default: r = "";
		endcase
		return r;
	endfunction

	task automatic test_random(int count);
		string p;
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				// noise: any byte at all
				send_word(8'($urandom_range(255)), $urandom_range(15) == 0);
				sent++;
			end else begin
				p = rand_piece();
				send_text(p);
				sent += p.len();
				send_word($urandom_range(1) ? " " : 8'($urandom_range(9, 13)), 0);
				sent++;
			end
			if (sent > count / 2 && sent < count / 2 + 12) begin
				quiet_src = 1;
				quiet_sink = 1;
			end else begin
				quiet_src = 0;
				quiet_sink = 0;
			end
		end
		send_word(0, 1);
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_sink = 1;
				repeat (60) @(posedge clk);
				hold_sink = 0;
			end
			send_text("select 'abc' -12.5e+3 x >= 7 ");
		join
		send_word(0, 1);
	endtask

	initial begin
		int drain;
		lx_mode = SC_IDLE;
		lx_kw = '{default: 0};
		lx_len = 0;
		lx_mag = 0;
		lx_neg = 0;
		lx_single = 0;
		lx_held = '{default: 0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_keywords();
		test_numbers();
		test_strings_ops();
		test_backpressure();
		test_random(24);
		chr_valid <= 1'b0;
		drain = 0;
		while (token_queue.size() != 0 && drain < 50000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		$display("Scanned %0d characters into %0d token words: keywords, numbers, reals,",
			words_sent, tokens_seen);
		$display("strings with escapes, operators, errors and a long output hold-off.");
		if (errors == 0 && token_queue.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
